// ===== hw/rtl/lva_pkg.sv =====
// Shared types, constants and helper functions of the LRU voice allocator.
// Used by the allocator, its output register and the testbench; depends on nothing else.
package lva_pkg;

	// Voice bank size and the widths that follow from it.
	localparam int NUM_VOICES = 16;
	localparam int VOICE_W    = $clog2(NUM_VOICES);
	localparam int CNT_W      = $clog2(NUM_VOICES + 1);
	localparam int NUM_NOTES  = 128;
	localparam int NOTE_W     = 7;
	localparam int VEL_W      = 7;
	localparam int MASK_BITS  = 16;
	localparam int OUT_VOICE_W = 4;

	// Voices covered by the all-notes-off sweep.
	localparam int SCAN_CNT = (NUM_VOICES < MASK_BITS) ? NUM_VOICES : MASK_BITS;
	localparam int SCAN_W   = (SCAN_CNT > 1) ? $clog2(SCAN_CNT) : 1;

	localparam logic [VOICE_W-1:0] LAST_V  = VOICE_W'(NUM_VOICES - 1);
	localparam logic [CNT_W-1:0]   VOICE_N = CNT_W'(NUM_VOICES);

	// Event kinds on the input channel.
	typedef enum logic [1:0] {
		OP_NOTE_ON  = 2'd0,
		OP_NOTE_OFF = 2'd1,
		OP_ALL_OFF  = 2'd2
	} op_t;

	// Commands to the voice units.
	typedef enum logic [1:0] {
		CMD_CANCEL   = 2'd0,
		CMD_NOTE_ON  = 2'd1,
		CMD_NOTE_OFF = 2'd2
	} cmd_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		S_IDLE,
		S_SRCH,
		S_CANCEL,
		S_SHIFT,
		S_TAIL,
		S_OFF_RD,
		S_OFF_EMIT,
		S_ALL_SCAN,
		S_ALL_VN,
		S_ALL_EMIT
	} state_t;

	// One result item on its way to the output register.
	typedef struct packed {
		cmd_t                   command;
		logic [OUT_VOICE_W-1:0] voice;
		logic [NOTE_W-1:0]      note;
		logic [VEL_W-1:0]       velocity;
		logic                   last;
	} lva_res_t;

	// A voice counts as sounding only if the mask has a bit for it.
	function automatic logic voice_sounding(logic [MASK_BITS-1:0] mask,
			logic [VOICE_W-1:0] v);
		logic [31:0] vx;
		vx = 32'(v);
		return (vx < 32'(MASK_BITS)) && mask[vx[3:0]];
	endfunction

	// The voice field carries the low four bits of the index.
	function automatic logic [OUT_VOICE_W-1:0] to_out_voice(logic [VOICE_W-1:0] v);
		logic [31:0] vx;
		vx = 32'(v);
		return vx[OUT_VOICE_W-1:0];
	endfunction

endpackage

// ===== hw/rtl/lva_vram.sv =====
// Generic synchronous RAM with one write and one registered read port.
// Each entry has a valid bit that reset clears; standalone, no package needed.
module lva_vram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 4,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata,
	output logic             rvalid,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [WIDTH-1:0] rdata_q;
	logic             rvalid_q;

	// Storage array and read data register; read data holds until the next read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	// Per-entry valid bits, cleared at once by reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (re) begin
				rvalid_q <= vld_q[raddr];
			end
		end
	end

	assign rdata  = rdata_q;
	assign rvalid = rvalid_q;

endmodule

// ===== hw/rtl/lva_out.sv =====
// Output register of the allocator: holds one result until it is taken.
// Depends on lva_pkg for the result type.
module lva_out
	import lva_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  lva_res_t               res,
	output logic                   room,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [1:0]             command,
	output logic [OUT_VOICE_W-1:0] voice,
	output logic [NOTE_W-1:0]      note_res,
	output logic [VEL_W-1:0]       velocity_res,
	output logic                   last
);

	logic     valid_q;
	lva_res_t res_q;

	// The register can load when empty or when its content leaves this cycle.
	assign room = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push && room) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	// Payload loads only on a new result, so a stalled transfer holds.
	always_ff @(posedge clk) begin
		if (push && room) begin
			res_q <= res;
		end
	end

	assign out_valid    = valid_q;
	assign command      = res_q.command;
	assign voice        = res_q.voice;
	assign note_res     = res_q.note;
	assign velocity_res = res_q.velocity;
	assign last         = res_q.last;

endmodule

// ===== hw/rtl/lru_voice_allocator_unit.sv =====
// LRU voice allocator: one event at a time; in_stall is high until its last result is queued.
// A note-on walks the LRU RAM, one entry per cycle, first to search for a silent voice and then
// to shift the entries above it down by one; a steal adds a cancel. A note-off reads the note map.
// All-notes-off sweeps the voices in ascending order and emits a note-off per sounding voice.
// Reset takes effect at once: valid bits make the note map and voice notes read as zero and
// the LRU order as the identity, with no clearing pass.
module lru_voice_allocator_unit
	import lva_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [1:0]             op,
	input  logic [NOTE_W-1:0]      note,
	input  logic [VEL_W-1:0]       velocity,
	input  logic [MASK_BITS-1:0]   active_mask,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [1:0]             command,
	output logic [OUT_VOICE_W-1:0] voice,
	output logic [NOTE_W-1:0]      note_res,
	output logic [VEL_W-1:0]       velocity_res,
	output logic                   last
);

	state_t state_q, state_d;

	logic                 accept;
	logic                 room;
	logic                 push;
	lva_res_t             res;

	logic [NOTE_W-1:0]    note_q;
	logic [VEL_W-1:0]     vel_q;
	logic [MASK_BITS-1:0] mask_q;
	logic [SCAN_CNT-1:0]  rem_q;
	logic [SCAN_W-1:0]    av_q;
	logic [CNT_W-1:0]     idx_q;
	logic                 pend_s1;
	logic [VOICE_W-1:0]   pidx_s1;
	logic [VOICE_W-1:0]   first_q;
	logic [VOICE_W-1:0]   v_q;
	logic [NOTE_W-1:0]    nt_q;

	// RAM ports.
	logic                 lru_re, lru_we, lru_rvalid;
	logic [VOICE_W-1:0]   lru_raddr, lru_waddr, lru_wdata, lru_rdata;
	logic                 ntv_re, ntv_we, ntv_rvalid;
	logic [NOTE_W-1:0]    ntv_raddr;
	logic [VOICE_W-1:0]   ntv_rdata;
	logic                 vn_re, vn_we, vn_rvalid;
	logic [VOICE_W-1:0]   vn_raddr;
	logic [NOTE_W-1:0]    vn_rdata;

	// Values read back, with the reset contents for entries never written.
	logic [VOICE_W-1:0]   lru_val;
	logic [VOICE_W-1:0]   ntv_val;
	logic [NOTE_W-1:0]    vn_val;
	logic                 sounding;
	logic                 all_last;
	logic [SCAN_CNT-1:0]  scan_mask;

	assign lru_val  = lru_rvalid ? lru_rdata : pidx_s1;
	assign ntv_val  = ntv_rvalid ? ntv_rdata : '0;
	assign vn_val   = vn_rvalid ? vn_rdata : '0;
	assign sounding = voice_sounding(mask_q, lru_val);
	assign scan_mask = active_mask[SCAN_CNT-1:0];
	assign all_last = (rem_q & ~(SCAN_CNT'(1) << av_q)) == '0;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;

	// LRU order, note-to-voice map and note held by each voice.
	lva_vram #(.DEPTH(NUM_VOICES), .WIDTH(VOICE_W)) u_lru (
		.clk(clk), .arst_n(arst_n),
		.re(lru_re), .raddr(lru_raddr), .rdata(lru_rdata), .rvalid(lru_rvalid),
		.we(lru_we), .waddr(lru_waddr), .wdata(lru_wdata)
	);

	lva_vram #(.DEPTH(NUM_NOTES), .WIDTH(VOICE_W)) u_ntv (
		.clk(clk), .arst_n(arst_n),
		.re(ntv_re), .raddr(ntv_raddr), .rdata(ntv_rdata), .rvalid(ntv_rvalid),
		.we(ntv_we), .waddr(note_q), .wdata(v_q)
	);

	lva_vram #(.DEPTH(NUM_VOICES), .WIDTH(NOTE_W)) u_vn (
		.clk(clk), .arst_n(arst_n),
		.re(vn_re), .raddr(vn_raddr), .rdata(vn_rdata), .rvalid(vn_rvalid),
		.we(vn_we), .waddr(v_q), .wdata(note_q)
	);

	// Output register.
	lva_out u_out (
		.clk(clk), .arst_n(arst_n),
		.push(push), .res(res), .room(room),
		.out_valid(out_valid), .out_stall(out_stall),
		.command(command), .voice(voice), .note_res(note_res),
		.velocity_res(velocity_res), .last(last)
	);

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pend_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_s1 <= lru_re && (state_d == state_q);
		end
	end

	// Next state, RAM strobes and the result being offered.
	always_comb begin
		state_d   = state_q;
		lru_re    = 1'b0;
		lru_raddr = idx_q[VOICE_W-1:0];
		lru_we    = 1'b0;
		lru_waddr = pidx_s1 - VOICE_W'(1);
		lru_wdata = lru_val;
		ntv_re    = 1'b0;
		ntv_raddr = note_q;
		ntv_we    = 1'b0;
		vn_re     = 1'b0;
		vn_raddr  = VOICE_W'(av_q);
		vn_we     = 1'b0;
		push      = 1'b0;
		res       = '{command: CMD_NOTE_OFF, voice: to_out_voice(ntv_val),
			note: note_q, velocity: '0, last: 1'b1};
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (op)
						OP_NOTE_ON:  state_d = S_SRCH;
						OP_NOTE_OFF: state_d = S_OFF_RD;
						OP_ALL_OFF: begin
							if (scan_mask != '0) begin
								state_d = S_ALL_SCAN;
							end
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			// Walk the LRU order from the oldest entry for a silent voice.
			S_SRCH: begin
				lru_re = (idx_q < VOICE_N);
				if (pend_s1 && !sounding) begin
					state_d = (pidx_s1 == LAST_V) ? S_TAIL : S_SHIFT;
				end else if (pend_s1 && pidx_s1 == LAST_V) begin
					state_d = S_CANCEL;
				end
			end
			// Every voice sounds: cancel the oldest one.
			S_CANCEL: begin
				push = 1'b1;
				res  = '{command: CMD_CANCEL, voice: to_out_voice(v_q),
					note: note_q, velocity: '0, last: 1'b0};
				if (room) begin
					state_d = S_SHIFT;
				end
			end
			// Close the gap: each entry above the chosen one moves down by one.
			S_SHIFT: begin
				lru_re = (idx_q < VOICE_N);
				lru_we = pend_s1;
				if (pend_s1 && pidx_s1 == LAST_V) begin
					state_d = S_TAIL;
				end
			end
			// Chosen voice becomes newest; record the note and issue note on.
			S_TAIL: begin
				push = 1'b1;
				res  = '{command: CMD_NOTE_ON, voice: to_out_voice(v_q),
					note: note_q, velocity: vel_q, last: 1'b1};
				lru_waddr = LAST_V;
				lru_wdata = v_q;
				if (room) begin
					lru_we  = 1'b1;
					ntv_we  = 1'b1;
					vn_we   = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_OFF_RD: begin
				ntv_re  = 1'b1;
				state_d = S_OFF_EMIT;
			end
			S_OFF_EMIT: begin
				push = 1'b1;
				if (room) begin
					state_d = S_IDLE;
				end
			end
			// Sweep voices in ascending order, stopping on each sounding one.
			S_ALL_SCAN: begin
				if (rem_q[av_q]) begin
					vn_re   = 1'b1;
					state_d = S_ALL_VN;
				end
			end
			S_ALL_VN: begin
				ntv_re    = 1'b1;
				ntv_raddr = vn_val;
				state_d   = S_ALL_EMIT;
			end
			S_ALL_EMIT: begin
				push = 1'b1;
				res  = '{command: CMD_NOTE_OFF, voice: to_out_voice(ntv_val),
					note: nt_q, velocity: '0, last: all_last};
				if (room) begin
					state_d = all_last ? S_IDLE : S_ALL_SCAN;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Event fields, walk counters and the voice picked by the search.
	always_ff @(posedge clk) begin
		pidx_s1 <= idx_q[VOICE_W-1:0];
		if (accept) begin
			note_q <= note;
			vel_q  <= velocity;
			mask_q <= active_mask;
			rem_q  <= scan_mask;
			idx_q  <= '0;
			av_q   <= '0;
		end
		unique case (state_q)
			S_SRCH: begin
				if (lru_re) begin
					idx_q <= idx_q + CNT_W'(1);
				end
				if (pend_s1 && pidx_s1 == '0) begin
					first_q <= lru_val;
				end
				if (pend_s1 && !sounding) begin
					v_q   <= lru_val;
					idx_q <= CNT_W'(pidx_s1) + CNT_W'(1);
				end else if (pend_s1 && pidx_s1 == LAST_V) begin
					v_q   <= first_q;
					idx_q <= CNT_W'(1);
				end
			end
			S_SHIFT: begin
				if (lru_re) begin
					idx_q <= idx_q + CNT_W'(1);
				end
			end
			S_ALL_SCAN: begin
				if (!rem_q[av_q]) begin
					av_q <= av_q + SCAN_W'(1);
				end
			end
			S_ALL_VN: begin
				nt_q <= vn_val;
			end
			S_ALL_EMIT: begin
				if (room) begin
					rem_q[av_q] <= 1'b0;
					av_q        <= av_q + SCAN_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// A cancel is never the final command of its event.
	a_cancel_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && command == CMD_CANCEL) |-> !last)
		else $error("cancel transfer marked as last");

	// A note on always closes its event.
	a_note_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && command == CMD_NOTE_ON) |-> last)
		else $error("note on transfer not marked as last");

	// The shift walk never writes below entry zero.
	a_shift_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT && pend_s1) |-> (pidx_s1 != '0))
		else $error("LRU shift write wrapped below entry zero");

	// The all-notes-off sweep only runs while a sounding voice is left.
	a_sweep_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ALL_SCAN) |-> (rem_q != '0))
		else $error("all-notes-off sweep with no voice left");

endmodule

// ===== dv/lru_voice_allocator_unit_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for lru_voice_allocator_unit: directed table, then random note events.
// Depends on lva_pkg and the allocator RTL; results are checked against an in-bench predictor.
module lru_voice_allocator_unit_tb;
	import lva_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int RAND_EVENTS = 220;
	localparam int MAX_REPORTS = 10;
	localparam int DRAIN_CYCLES = 80;
	localparam int CYCLE_LIMIT = 400000;

	// One note event as it is offered on the input channel.
	typedef struct packed {
		logic [1:0]           op;
		logic [NOTE_W-1:0]    note;
		logic [VEL_W-1:0]     vel;
		logic [MASK_BITS-1:0] mask;
	} note_event_t;

	// One row of the directed table; typed rows carry their own expectation.
	typedef struct packed {
		note_event_t ev;
		logic        typed;
		logic        has_cmd;
		lva_res_t    cmd;
	} table_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] op = '0;
	logic [NOTE_W-1:0] note = '0;
	logic [VEL_W-1:0] velocity = '0;
	logic [MASK_BITS-1:0] active_mask = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] command;
	logic [OUT_VOICE_W-1:0] voice;
	logic [NOTE_W-1:0] note_res;
	logic [VEL_W-1:0] velocity_res;
	logic last;

	lru_voice_allocator_unit dut (.*);

	// Predictor state: voice age order (oldest first), note map and note per voice.
	logic [VOICE_W-1:0] age_order [NUM_VOICES];
	logic [VOICE_W-1:0] key_voice [NUM_NOTES];
	logic [NOTE_W-1:0]  held_key  [NUM_VOICES];
	logic [VOICE_W-1:0] last_on_voice;

	lva_res_t voice_cmds_due [$];
	table_row_t directed_rows [$];
	bit calm = 1'b0;
	int cycle_cnt = 0;
	int err_cnt = 0;
	int checked_cnt = 0;
	int steal_cnt = 0;
	int op_cnt [4] = '{0, 0, 0, 0};

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
	end

	// Wait before an item or a result: none during calm stretches, else mostly random.
	function automatic int draw_wait();
		if (calm || $urandom_range(0, 3) == 0)
			return 0;
		return $urandom_range(0, 14);
	endfunction

	// Works out the voice commands one event causes and queues them; returns how many.
	function automatic int allocate_voices(input note_event_t e);
		int n;
		int pos;
		logic [VOICE_W-1:0] v;
		n = 0;
		case (e.op)
			OP_NOTE_ON: begin
				pos = -1;
				for (int i = 0; i < NUM_VOICES; i++) begin
					if (pos < 0 && !(int'(age_order[i]) < MASK_BITS && e.mask[age_order[i]]))
						pos = i;
				end
				// Every voice is sounding: the oldest one is stolen.
				if (pos < 0) begin
					pos = 0;
					voice_cmds_due.push_back('{CMD_CANCEL, age_order[0], e.note, '0, 1'b0});
					steal_cnt++;
					n++;
				end
				v = age_order[pos];
				for (int i = pos; i < NUM_VOICES - 1; i++)
					age_order[i] = age_order[i + 1];
				age_order[NUM_VOICES - 1] = v;
				key_voice[e.note] = v;
				held_key[v] = e.note;
				last_on_voice = v;
				voice_cmds_due.push_back('{CMD_NOTE_ON, v, e.note, e.vel, 1'b1});
				n++;
			end
			OP_NOTE_OFF: begin
				// The map is never cleared, so a reused voice still gets the note-off.
				voice_cmds_due.push_back('{CMD_NOTE_OFF, key_voice[e.note], e.note, '0, 1'b1});
				n++;
			end
			OP_ALL_OFF: begin
				for (int i = 0; i < NUM_VOICES && i < MASK_BITS; i++) begin
					if (e.mask[i]) begin
						voice_cmds_due.push_back('{CMD_NOTE_OFF, key_voice[held_key[i]],
							held_key[i], '0, 1'b0});
						n++;
					end
				end
				if (n > 0)
					voice_cmds_due[$].last = 1'b1;
			end
			default: begin
			end
		endcase
		return n;
	endfunction

	// Offers one event after the given wait and returns at the edge of its transfer.
	task automatic send_event(input note_event_t e, input int gap, input logic typed,
			input logic has_cmd, input lva_res_t cmd);
		int n;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= e.op;
		note <= e.note;
		velocity <= e.vel;
		active_mask <= e.mask;
		do
			@(posedge clk);
		while (in_stall);
		n = allocate_voices(e);
		op_cnt[e.op]++;
		// Rows with a typed expectation replace what the predictor queued.
		if (typed) begin
			repeat (n) void'(voice_cmds_due.pop_back());
			if (has_cmd)
				voice_cmds_due.push_back(cmd);
		end
	endtask

	function automatic void add_row(input logic [1:0] o, input int k, input int vl,
			input logic [MASK_BITS-1:0] m, input logic typed, input logic has_cmd,
			input lva_res_t cmd);
		table_row_t r;
		r.ev = '{o, NOTE_W'(k), VEL_W'(vl), m};
		r.typed = typed;
		r.has_cmd = has_cmd;
		r.cmd = cmd;
		directed_rows.push_back(r);
	endfunction

	// Result side: stall for a random number of cycles, then take one transfer.
	initial begin : result_sink
		int hold;
		@(posedge clk iff arst_n);
		forever begin
			hold = draw_wait();
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do
				@(posedge clk);
			while (!(out_valid && !out_stall));
		end
	end

	// Compare every result transfer with the oldest expected command.
	always @(posedge clk) begin
		lva_res_t exp_cmd;
		if (arst_n && out_valid && !out_stall) begin
			if (voice_cmds_due.size() == 0) begin
				err_cnt++;
				if (err_cnt <= MAX_REPORTS)
					$display("unexpected command %0d voice %0d note %0d vel %0d last %0d",
						command, voice, note_res, velocity_res, last);
			end else begin
				exp_cmd = voice_cmds_due.pop_front();
				checked_cnt++;
				if (command != exp_cmd.command || voice != exp_cmd.voice ||
						note_res != exp_cmd.note || velocity_res != exp_cmd.velocity ||
						last != exp_cmd.last) begin
					err_cnt++;
					if (err_cnt <= MAX_REPORTS) begin
						$display("mismatch: expected cmd %0d voice %0d note %0d vel %0d last %0d",
							exp_cmd.command, exp_cmd.voice, exp_cmd.note,
							exp_cmd.velocity, exp_cmd.last);
						$display("          got cmd %0d voice %0d note %0d vel %0d last %0d",
							command, voice, note_res, velocity_res, last);
					end
				end
			end
		end
	end

	// Runaway guard.
	initial begin : watchdog
		while (cycle_cnt < CYCLE_LIMIT)
			@(posedge clk);
		$display("timeout after %0d cycles", cycle_cnt);
		$display("status: fail");
		$finish;
	end

	initial begin : stimulus
		note_event_t e;
		logic [MASK_BITS-1:0] live;
		logic [NOTE_W-1:0] recent [$];
		int sent;
		int pick;
		int m;

		for (int i = 0; i < NUM_VOICES; i++) begin
			age_order[i] = VOICE_W'(i);
			held_key[i] = '0;
		end
		for (int i = 0; i < NUM_NOTES; i++)
			key_voice[i] = '0;
		live = '0;

		// Directed table; typed rows are read straight off the reset state.
		add_row(OP_NOTE_OFF, 0, 0, 16'h0000, 1, 1, '{CMD_NOTE_OFF, 4'd0, 7'd0, 7'd0, 1'b1});
		add_row(OP_NOTE_OFF, 127, 127, 16'hFFFF, 1, 1,
			'{CMD_NOTE_OFF, 4'd0, 7'd127, 7'd0, 1'b1});
		add_row(OP_ALL_OFF, 0, 0, 16'h0000, 1, 0, '0);
		add_row(OP_UNUSED, 127, 127, 16'hFFFF, 1, 0, '0);
		add_row(OP_ALL_OFF, 0, 0, 16'hFFFF, 0, 0, '0);
		add_row(OP_NOTE_ON, 127, 127, 16'h0000, 1, 1,
			'{CMD_NOTE_ON, 4'd0, 7'd127, 7'd127, 1'b1});
		add_row(OP_NOTE_ON, 0, 0, 16'h0001, 1, 1, '{CMD_NOTE_ON, 4'd1, 7'd0, 7'd0, 1'b1});
		add_row(OP_NOTE_ON, 60, 100, 16'hFFFF, 0, 0, '0);
		add_row(OP_NOTE_ON, 61, 1, 16'hFFFE, 0, 0, '0);
		add_row(OP_NOTE_ON, 62, 64, 16'h7FFF, 0, 0, '0);
		add_row(OP_NOTE_OFF, 60, 5, 16'h0000, 0, 0, '0);
		add_row(OP_NOTE_OFF, 127, 0, 16'h0000, 0, 0, '0);
		add_row(OP_ALL_OFF, 9, 9, 16'h8001, 0, 0, '0);
		add_row(OP_ALL_OFF, 0, 0, 16'hFFFF, 0, 0, '0);
		add_row(OP_NOTE_ON, 60, 127, 16'hFFFF, 0, 0, '0);
		add_row(OP_NOTE_ON, 5, 33, 16'hAAAA, 0, 0, '0);
		add_row(OP_NOTE_ON, 6, 66, 16'h5555, 0, 0, '0);
		add_row(OP_NOTE_OFF, 5, 0, 16'hFFFF, 0, 0, '0);
		add_row(OP_ALL_OFF, 0, 0, 16'h5555, 0, 0, '0);
		add_row(OP_ALL_OFF, 0, 0, 16'hAAAA, 0, 0, '0);
		add_row(OP_NOTE_ON, 127, 127, 16'h0000, 0, 0, '0);
		add_row(OP_NOTE_ON, 0, 127, 16'hFFFF, 0, 0, '0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_event(directed_rows[i].ev, draw_wait(), directed_rows[i].typed,
				directed_rows[i].has_cmd, directed_rows[i].cmd);

		// Random part: the mask often follows the voices started here, so steals occur.
		sent = 0;
		while (sent < RAND_EVENTS) begin
			calm = ((sent / 30) % 3) == 2;
			pick = $urandom_range(0, 99);
			e.note = NOTE_W'($urandom_range(0, 127));
			e.vel = VEL_W'($urandom_range(0, 127));
			if (pick < 45) begin
				e.op = OP_NOTE_ON;
			end else if (pick < 80) begin
				e.op = OP_NOTE_OFF;
				if (recent.size() > 0 && $urandom_range(0, 3) != 0)
					e.note = recent[$urandom_range(0, recent.size() - 1)];
			end else if (pick < 95) begin
				e.op = OP_ALL_OFF;
			end else begin
				e.op = OP_UNUSED;
			end
			m = $urandom_range(0, 99);
			if (m < 50)
				e.mask = ($urandom_range(0, 2) == 0) ?
					live ^ (MASK_BITS'(1) << $urandom_range(0, MASK_BITS - 1)) : live;
			else if (m < 65)
				e.mask = '1;
			else if (m < 75)
				e.mask = '0;
			else
				e.mask = MASK_BITS'($urandom());
			send_event(e, draw_wait(), 1'b0, 1'b0, '0);

			// Track which voices a real voice bank would still have sounding.
			case (e.op)
				OP_NOTE_ON: begin
					live[last_on_voice] = 1'b1;
					recent.push_back(e.note);
					if (recent.size() > 16)
						void'(recent.pop_front());
				end
				OP_NOTE_OFF: begin
					if ($urandom_range(0, 1) == 0)
						live[key_voice[e.note]] = 1'b0;
				end
				OP_ALL_OFF: begin
					if ($urandom_range(0, 3) != 0)
						live = '0;
				end
				default: begin
				end
			endcase
			if (e.op != OP_UNUSED)
				sent++;
		end
		in_valid <= 1'b0;

		while (voice_cmds_due.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d note-on (%0d steals), %0d note-off, %0d all-off, %0d unused events.",
			op_cnt[OP_NOTE_ON], steal_cnt, op_cnt[OP_NOTE_OFF], op_cnt[OP_ALL_OFF],
			op_cnt[OP_UNUSED]);
		$display("Checked %0d voice commands with %0d errors.", checked_cnt, err_cnt);
		if (err_cnt == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/lva_pkg.sv
hw/rtl/lva_vram.sv
hw/rtl/lva_out.sv
hw/rtl/lru_voice_allocator_unit.sv
dv/lru_voice_allocator_unit_tb.sv
